>>> rtl/ctf_pkg.sv
// Shared types and constants of the complementary tilt filter.
// Depends on nothing; every other file of the block imports it.
package ctf_pkg;

  // Register file
  localparam int ADDR_W = 3;
  localparam logic REG_BLEND_WEIGHT  = 1'b0;
  localparam logic REG_SAMPLE_PERIOD = 1'b1;
  localparam logic [15:0] BLEND_WEIGHT_RESET  = 16'd64225;
  localparam logic [15:0] SAMPLE_PERIOD_RESET = 16'd655;

  // Datapath widths
  localparam int SQ_W       = 48;  // (ay^2 + az^2) * 2^16
  localparam int ROOT_W     = 24;  // floor square root of the above, Q8 counts
  localparam int VEC_W      = 25;  // CORDIC operands in Q8 counts
  localparam int MAX_STAGES = 24;
  localparam int ITER_W     = 5;   // holds any stage index below MAX_STAGES

  // CORDIC arctangent table, Q16 degrees, rounded to nearest
  localparam logic [21:0] ATAN_TAB [MAX_STAGES] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  // One classified sample as it waits in the queue
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic [SQ_W-1:0]    mag2;
  } sample_t;

  typedef struct packed {
    logic [15:0] blend_weight;
    logic [15:0] sample_period;
  } cfg_t;

  typedef struct packed {
    logic                    start;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] x;
  } cord_req_t;

  typedef struct packed {
    logic               busy;
    logic signed [15:0] angle;
  } cord_rsp_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] mag2;
  } sqrt_req_t;

  typedef struct packed {
    logic              busy;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  // Back-end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ANG_P,
    BK_ANG_R,
    BK_BLD_R,
    BK_DONE
  } bk_state_t;

  // Steps of one estimate update on the shared multiplier
  typedef enum logic [2:0] {
    BL_RATE,
    BL_SUM,
    BL_LOW,
    BL_HIGH,
    BL_INST,
    BL_FINAL,
    BL_WRITE,
    BL_HOLD
  } bl_step_t;

endpackage

>>> rtl/complementary_tilt_filter_unit.sv
// Top level of the complementary tilt filter: register file, front end,
// square root, CORDIC and back end. Depends on ctf_pkg and all ctf_ modules.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  accel_x, accel_y, accel_z, rate_x, rate_y
//   out       output     out_valid/out_stall  pitch_est, roll_est, pitch_instant,
//                                             roll_instant
//   config    input      APB psel/penable     blend_weight @0x0, sample_period @0x4
//
// A sample in the back end makes two vectoring passes through the one CORDIC unit,
// and the second of them, the roll pass, also waits for the square root.
// The square root runs beside the pitch pass; the pitch update runs beside
// the roll pass. The front end holds one sample and the queue two more, so
// input is taken while the back end works or a result waits. Reset zeroes
// both estimates and loads the register defaults; no clearing pass is needed.
module complementary_tilt_filter_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ctf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [15:0]         in_accel_x,
  input  logic signed [15:0]         in_accel_y,
  input  logic signed [15:0]         in_accel_z,
  input  logic signed [15:0]         in_rate_x,
  input  logic signed [15:0]         in_rate_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [15:0]         out_pitch_est,
  output logic signed [15:0]         out_roll_est,
  output logic signed [15:0]         out_pitch_instant,
  output logic signed [15:0]         out_roll_instant
);
  import ctf_pkg::*;

  logic [15:0] blend_weight_r, sample_period_r;
  logic        cfg_wr;
  cfg_t        cfg;
  logic        q_vld, q_pop;
  sample_t     q_item;
  cord_req_t   cord_req;
  cord_rsp_t   cord_rsp;
  sqrt_req_t   sqrt_req;
  sqrt_rsp_t   sqrt_rsp;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_weight_r  <= BLEND_WEIGHT_RESET;
      sample_period_r <= SAMPLE_PERIOD_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SAMPLE_PERIOD) begin
        sample_period_r <= pwdata[15:0];
      end else begin
        blend_weight_r <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_BLEND_WEIGHT) ? {16'h0000, blend_weight_r}
                                                 : {16'h0000, sample_period_r};
  assign cfg.blend_weight  = blend_weight_r;
  assign cfg.sample_period = sample_period_r;

  ctf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_accel_x (in_accel_x),
    .in_accel_y (in_accel_y),
    .in_accel_z (in_accel_z),
    .in_rate_x  (in_rate_x),
    .in_rate_y  (in_rate_y),
    .q_pop      (q_pop),
    .q_vld      (q_vld),
    .q_item     (q_item)
  );

  ctf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  ctf_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cord_req),
    .rsp   (cord_rsp)
  );

  ctf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .q_vld             (q_vld),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .cord_req          (cord_req),
    .cord_rsp          (cord_rsp),
    .sqrt_req          (sqrt_req),
    .sqrt_rsp          (sqrt_rsp),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pitch_est     (out_pitch_est),
    .out_roll_est      (out_roll_est),
    .out_pitch_instant (out_pitch_instant),
    .out_roll_instant  (out_roll_instant)
  );

`ifndef SYNTH
  // A CORDIC pass never starts over one still in flight.
  a_cord_start: assert property (@(posedge clk) disable iff (!rst_n)
    cord_req.start |-> !cord_rsp.busy)
    else $error("CORDIC started while busy");

  // The square root never restarts while still iterating.
  a_sqrt_start: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_req.start |-> !sqrt_rsp.busy)
    else $error("square root started while busy");

  // The back end only takes a sample that the queue holds.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_vld)
    else $error("queue popped while empty");

  // Instant angles stay within a half turn.
  a_inst_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_instant >= -16'sd23040) && (out_pitch_instant <= 16'sd23040)
              && (out_roll_instant >= -16'sd23040) && (out_roll_instant <= 16'sd23040))
    else $error("instant angle out of range");
`endif

endmodule

>>> rtl/ctf_front.sv
// Front end: input stage that squares the y and z axes, and a two-entry
// sample queue toward the back end. Depends on ctf_pkg.
module ctf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_rate_x,
  input  logic signed [15:0] in_rate_y,
  input  logic               q_pop,
  output logic               q_vld,
  output ctf_pkg::sample_t   q_item
);
  import ctf_pkg::*;

  logic               stg_vld_r;
  logic signed [15:0] stg_ax_r, stg_ay_r, stg_az_r, stg_rx_r, stg_ry_r;
  logic [30:0]        sq_y_r, sq_z_r;
  logic signed [31:0] sq_y, sq_z;
  logic               accept, push, q_full;
  logic [31:0]        sq_sum;

  sample_t            ent_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         cnt_r;

  // Squares of the two axes that form the tilt magnitude
  assign sq_y = 32'(in_accel_y) * 32'(in_accel_y);
  assign sq_z = 32'(in_accel_z) * 32'(in_accel_z);

  assign q_full   = (cnt_r == 2'd2);
  assign q_vld    = (cnt_r != 2'd0);
  assign q_item   = ent_r[rd_ptr_r];
  assign in_stall = stg_vld_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = stg_vld_r && !q_full;
  assign sq_sum   = {1'b0, sq_y_r} + {1'b0, sq_z_r};

  // Input stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (accept) begin
      stg_vld_r <= 1'b1;
    end else if (push) begin
      stg_vld_r <= 1'b0;
    end
  end

  // Input stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      stg_ax_r <= in_accel_x;
      stg_ay_r <= in_accel_y;
      stg_az_r <= in_accel_z;
      stg_rx_r <= in_rate_x;
      stg_ry_r <= in_rate_y;
      sq_y_r   <= sq_y[30:0];
      sq_z_r   <= sq_z[30:0];
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (q_pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Queue entries
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= '{accel_x: stg_ax_r, accel_y: stg_ay_r, accel_z: stg_az_r,
                           rate_x: stg_rx_r, rate_y: stg_ry_r,
                           mag2: {sq_sum, 16'h0000}};
    end
  end

endmodule

>>> rtl/ctf_sqrt.sv
// Iterative floor square root, two result bits per cycle.
// Depends on ctf_pkg.
module ctf_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  ctf_pkg::sqrt_req_t  req,
  output ctf_pkg::sqrt_rsp_t  rsp
);
  import ctf_pkg::*;

  localparam logic [SQ_W-1:0] BIT_START = SQ_W'(1) << (SQ_W - 2);
  localparam logic [SQ_W-1:0] BIT_LAST  = SQ_W'(4);

  logic            busy_r;
  logic [SQ_W-1:0] rem_r, root_r, bit_r;
  logic [SQ_W:0]   t1, t2;
  logic            ge1, ge2;
  logic [SQ_W-1:0] rem1, root1, bit2, rem2, root2;

  // Two restoring steps: trial bit, then the bit two places lower
  always_comb begin
    t1    = {1'b0, root_r} + {1'b0, bit_r};
    ge1   = ({1'b0, rem_r} >= t1);
    rem1  = ge1 ? (rem_r - t1[SQ_W-1:0]) : rem_r;
    root1 = ge1 ? ((root_r >> 1) + bit_r) : (root_r >> 1);
    bit2  = bit_r >> 2;
    t2    = {1'b0, root1} + {1'b0, bit2};
    ge2   = ({1'b0, rem1} >= t2);
    rem2  = ge2 ? (rem1 - t2[SQ_W-1:0]) : rem1;
    root2 = ge2 ? ((root1 >> 1) + bit2) : (root1 >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (bit_r == BIT_LAST)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.mag2;
      root_r <= '0;
      bit_r  <= BIT_START;
    end else if (busy_r) begin
      rem_r  <= rem2;
      root_r <= root2;
      bit_r  <= bit_r >> 4;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.root = root_r[ROOT_W-1:0];

endmodule

>>> rtl/ctf_cordic.sv
// Iterative CORDIC vectoring unit: atan2(y, x) in 1/128 degree, one
// micro-rotation per cycle. Depends on ctf_pkg.
module ctf_cordic #(
  parameter int STAGES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ctf_pkg::cord_req_t  req,
  output ctf_pkg::cord_rsp_t  rsp
);
  import ctf_pkg::*;

  localparam int NITER  = (STAGES < MAX_STAGES) ? STAGES : MAX_STAGES;
  localparam int CORD_W = 44;
  localparam int Z_W    = 26;
  localparam logic signed [Z_W-1:0] Z_HALF   = 26'sd11796480;  // 180 degrees, Q16
  localparam logic signed [Z_W-1:0] Z_ROUND  = 26'sd256;
  localparam logic signed [Z_W-1:0] ANG_MAX  = 26'sd23040;

  logic                     busy_r, zero_r;
  logic signed [CORD_W-1:0] x_r, y_r;
  logic signed [Z_W-1:0]    z_r;
  logic [ITER_W-1:0]        i_r;
  logic signed [CORD_W-1:0] xs, ys, dx, dy;
  logic signed [Z_W-1:0]    tab, z_rnd;
  logic signed [15:0]       angle;

  assign xs  = CORD_W'(req.x) <<< 16;
  assign ys  = CORD_W'(req.y) <<< 16;
  assign dx  = y_r >>> i_r;
  assign dy  = x_r >>> i_r;
  assign tab = {4'b0000, ATAN_TAB[i_r]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (i_r == ITER_W'(NITER - 1))) begin
      busy_r <= 1'b0;
    end
  end

  // Vectors in the left half plane are turned by 180 degrees first
  always_ff @(posedge clk) begin
    if (req.start) begin
      zero_r <= (req.x == '0) && (req.y == '0);
      i_r    <= '0;
      if (req.x < 0) begin
        x_r <= -xs;
        y_r <= -ys;
        z_r <= (req.y >= 0) ? Z_HALF : -Z_HALF;
      end else begin
        x_r <= xs;
        y_r <= ys;
        z_r <= '0;
      end
    end else if (busy_r) begin
      i_r <= i_r + ITER_W'(1);
      if (y_r >= 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + tab;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - tab;
      end
    end
  end

  // Round Q16 degrees to 1/128 degree and clamp to a half turn
  always_comb begin
    z_rnd = (z_r + Z_ROUND) >>> 9;
    if (zero_r) begin
      angle = '0;
    end else if (z_rnd > ANG_MAX) begin
      angle = ANG_MAX[15:0];
    end else if (z_rnd < -ANG_MAX) begin
      angle = 16'(-ANG_MAX);
    end else begin
      angle = z_rnd[15:0];
    end
  end

  assign rsp.busy  = busy_r;
  assign rsp.angle = angle;

endmodule

>>> rtl/ctf_back.sv
// Back end: sequences the square root and the two CORDIC passes, blends
// both estimates on one shared multiplier and holds the result register.
// Depends on ctf_pkg.
module ctf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ctf_pkg::cfg_t       cfg,
  input  logic                q_vld,
  input  ctf_pkg::sample_t    q_item,
  output logic                q_pop,
  output ctf_pkg::cord_req_t  cord_req,
  input  ctf_pkg::cord_rsp_t  cord_rsp,
  output ctf_pkg::sqrt_req_t  sqrt_req,
  input  ctf_pkg::sqrt_rsp_t  sqrt_rsp,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_pitch_est,
  output logic signed [15:0]  out_roll_est,
  output logic signed [15:0]  out_pitch_instant,
  output logic signed [15:0]  out_roll_instant
);
  import ctf_pkg::*;

  bk_state_t          state_r, state_nxt;
  bl_step_t           step_r, step_nxt;
  logic               load_pinst, load_rinst, blend_run, blend_roll, out_load;

  logic signed [15:0] ax_r, rx_r, ry_r, pinst_r, rinst_r;
  logic signed [31:0] pitch_acc_r, roll_acc_r;
  logic signed [40:0] w_r;
  logic signed [59:0] acc_r;
  logic signed [42:0] prod_r;

  logic signed [31:0] est_sel;
  logic signed [15:0] rate_sel, inst_sel;
  logic signed [17:0] mul_a, alpha, ialpha;
  logic signed [24:0] mul_b;
  logic signed [42:0] prod_full;
  logic signed [59:0] acc_rnd;
  logic signed [31:0] est_new;

  logic               out_valid_r;
  logic signed [15:0] pe_r, re_r, pi_r, ri_r;

  // Round an estimate to 1/128 degree and saturate to 16 bits
  function automatic logic signed [15:0] sat_out(input logic signed [31:0] v);
    logic signed [32:0] t;
    t = (33'(v) + 33'sd128) >>> 8;
    if (t > 33'sd32767) begin
      sat_out = 16'sh7fff;
    end else if (t < -33'sd32768) begin
      sat_out = 16'sh8000;
    end else begin
      sat_out = t[15:0];
    end
  endfunction

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      step_r  <= BL_HOLD;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state and unit requests
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    q_pop         = 1'b0;
    load_pinst    = 1'b0;
    load_rinst    = 1'b0;
    blend_run     = 1'b0;
    blend_roll    = 1'b0;
    out_load      = 1'b0;
    cord_req      = '0;
    sqrt_req      = '0;
    case (state_r)
      BK_IDLE: begin
        if (q_vld) begin
          q_pop          = 1'b1;
          sqrt_req.start = 1'b1;
          sqrt_req.mag2  = q_item.mag2;
          cord_req.start = 1'b1;
          cord_req.y     = {q_item.accel_y[15], q_item.accel_y, 8'h00};
          cord_req.x     = {q_item.accel_z[15], q_item.accel_z, 8'h00};
          state_nxt      = BK_ANG_P;
        end
      end
      BK_ANG_P: begin
        if (!cord_rsp.busy && !sqrt_rsp.busy) begin
          load_pinst     = 1'b1;
          cord_req.start = 1'b1;
          cord_req.y     = {ax_r[15], ax_r, 8'h00};
          cord_req.x     = {1'b0, sqrt_rsp.root};
          step_nxt       = BL_RATE;
          state_nxt      = BK_ANG_R;
        end
      end
      BK_ANG_R: begin
        // Pitch blend runs while the roll pass is in the CORDIC
        blend_run = 1'b1;
        if (step_r != BL_HOLD) begin
          step_nxt = bl_step_t'(step_r + 3'd1);
        end
        if (!cord_rsp.busy && (step_r == BL_HOLD)) begin
          load_rinst = 1'b1;
          step_nxt   = BL_RATE;
          state_nxt  = BK_BLD_R;
        end
      end
      BK_BLD_R: begin
        blend_run  = 1'b1;
        blend_roll = 1'b1;
        if (step_r != BL_HOLD) begin
          step_nxt = bl_step_t'(step_r + 3'd1);
        end else begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Sample fields the later steps still need
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ax_r <= q_item.accel_x;
      rx_r <= q_item.rate_x;
      ry_r <= q_item.rate_y;
    end
    if (load_pinst) begin
      pinst_r <= cord_rsp.angle;
    end
    if (load_rinst) begin
      rinst_r <= cord_rsp.angle;
    end
  end

  // Operand selection for the shared 18 x 25 multiplier
  assign est_sel  = blend_roll ? roll_acc_r : pitch_acc_r;
  assign rate_sel = blend_roll ? rx_r : ry_r;
  assign inst_sel = blend_roll ? rinst_r : pinst_r;
  assign alpha    = {2'b00, cfg.blend_weight};
  assign ialpha   = {1'b0, 17'h10000 - {1'b0, cfg.blend_weight}};

  always_comb begin
    case (step_r)
      BL_RATE: begin
        mul_a = {{2{rate_sel[15]}}, rate_sel};
        mul_b = {9'b0, cfg.sample_period};
      end
      BL_LOW: begin
        mul_a = alpha;
        mul_b = {1'b0, w_r[23:0]};
      end
      BL_HIGH: begin
        mul_a = alpha;
        mul_b = {{8{w_r[40]}}, w_r[40:24]};
      end
      BL_INST: begin
        mul_a = ialpha;
        mul_b = {{9{inst_sel[15]}}, inst_sel};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = 43'(mul_a) * 43'(mul_b);

  // Round the blended value to 1/32768 degree and saturate to 32 bits
  always_comb begin
    acc_rnd = (acc_r + 60'sd8388608) >>> 24;
    if (acc_rnd > 60'sd2147483647) begin
      est_new = 32'sh7fffffff;
    end else if (acc_rnd < -60'sd2147483648) begin
      est_new = 32'sh80000000;
    end else begin
      est_new = acc_rnd[31:0];
    end
  end

  // Blend datapath: alpha * (est*2^8 + rate*dt) - (1 - alpha) * inst * 2^16
  always_ff @(posedge clk) begin
    if (blend_run) begin
      prod_r <= prod_full;
      case (step_r)
        BL_SUM: begin
          w_r <= {est_sel[31], est_sel, 8'h00} + 41'(prod_r);
        end
        BL_HIGH: begin
          acc_r <= 60'(prod_r);
        end
        BL_INST: begin
          acc_r <= acc_r + (60'(prod_r) <<< 24);
        end
        BL_FINAL: begin
          acc_r <= acc_r - (60'(prod_r) <<< 16);
        end
        default: begin
        end
      endcase
    end
  end

  // Filter estimates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_acc_r <= '0;
      roll_acc_r  <= '0;
    end else if (blend_run && (step_r == BL_WRITE)) begin
      if (blend_roll) begin
        roll_acc_r <= est_new;
      end else begin
        pitch_acc_r <= est_new;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pe_r <= sat_out(pitch_acc_r);
      re_r <= sat_out(roll_acc_r);
      pi_r <= pinst_r;
      ri_r <= rinst_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pitch_est     = pe_r;
  assign out_roll_est      = re_r;
  assign out_pitch_instant = pi_r;
  assign out_roll_instant  = ri_r;

endmodule

>>> tb/tb_complementary_tilt_filter_unit.sv
// Self-checking testbench for complementary_tilt_filter_unit: drives IMU samples and
// APB register writes, predicts each result in SystemVerilog (a pinned row gives its own) and checks it.
// Depends on ctf_pkg and the RTL of the filter; needs no other file.
module tb_complementary_tilt_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ctf_pkg::*;

  localparam int STAGES = 16;
  localparam int SETTLE_CYCLES = 100;
  localparam longint TIMEOUT_NS = 64'd6_000_000;

  // One IMU sample and one filter result, at the widths of the ports
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
  } imu_sample_t;

  typedef struct packed {
    logic signed [15:0] pitch_est;
    logic signed [15:0] roll_est;
    logic signed [15:0] pitch_instant;
    logic signed [15:0] roll_instant;
  } tilt_t;

  // A directed row; pinned rows carry a result typed in by hand
  typedef struct packed {
    imu_sample_t sample;
    logic        pinned;
    tilt_t       want;
  } probe_row_t;

  // Register settings of one phase of random traffic
  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] dt;
    int          count;
    logic        idling;
    logic        rate_push;
  } phase_t;

  // Arctangent of 2^-i in Q16 degrees, rounded to nearest
  localparam longint ARCTAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_accel_x = '0;
  logic signed [15:0] in_accel_y = '0;
  logic signed [15:0] in_accel_z = '0;
  logic signed [15:0] in_rate_x = '0;
  logic signed [15:0] in_rate_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_pitch_est;
  logic signed [15:0] out_roll_est;
  logic signed [15:0] out_pitch_instant;
  logic signed [15:0] out_roll_instant;

  // Predictor state: register copies and the two estimates in 1/32768 degree
  logic [15:0] alpha_q = BLEND_WEIGHT_RESET;
  logic [15:0] dt_q = SAMPLE_PERIOD_RESET;
  int pitch_track = 0;
  int roll_track = 0;

  tilt_t pending_tilt[$];
  int errors = 0;
  logic idle_on = 1'b0;
  int stall_left = 0;

  complementary_tilt_filter_unit #(
    .CORDIC_STAGES(STAGES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_accel_x(in_accel_x),
    .in_accel_y(in_accel_y),
    .in_accel_z(in_accel_z),
    .in_rate_x(in_rate_x),
    .in_rate_y(in_rate_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pitch_est(out_pitch_est),
    .out_roll_est(out_roll_est),
    .out_pitch_instant(out_pitch_instant),
    .out_roll_instant(out_roll_instant)
  );

  always #6 clk = ~clk;

  // Floor square root, one result bit per pass
  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitpos;
    rem = s;
    root = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > s) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (rem >= root + bitpos) begin
        rem = rem - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root = root >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return root;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Vectoring CORDIC: atan2(y, x) in 1/128 degree, operands in Q8 counts
  function automatic longint vector_angle(longint y, longint x);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // Left half plane: turn the vector by 180 degrees first
    if (x < 0) begin
      z = (y >= 0) ? (64'sd180 <<< 16) : -(64'sd180 <<< 16);
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_Q16[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_Q16[i];
      end
    end
    return clip((z + 256) >>> 9, -23040, 23040);
  endfunction

  // One estimate update: gyro integration blended with the negated instant angle
  function automatic int blend_estimate(int track, longint rate, longint inst);
    longint a;
    longint dt;
    longint w;
    longint v;
    a = alpha_q;
    dt = dt_q;
    w = longint'(track) * 256 + rate * dt;
    v = a * w - (65536 - a) * (inst * 65536);
    return int'(clip((v + (64'sd1 <<< 23)) >>> 24, -64'sd2147483648, 64'sd2147483647));
  endfunction

  function automatic tilt_t advance_filter(imu_sample_t s);
    longint ax;
    longint ay;
    longint az;
    longint mag;
    longint p_inst;
    longint r_inst;
    tilt_t res;
    ax = s.accel_x;
    ay = s.accel_y;
    az = s.accel_z;
    mag = longint'(floor_sqrt(longint'(ay * ay + az * az) * 65536));
    p_inst = vector_angle(ay * 256, az * 256);
    r_inst = vector_angle(ax * 256, mag);
    pitch_track = blend_estimate(pitch_track, s.rate_y, p_inst);
    roll_track = blend_estimate(roll_track, s.rate_x, r_inst);
    res.pitch_est = 16'(clip((longint'(pitch_track) + 128) >>> 8, -32768, 32767));
    res.roll_est = 16'(clip((longint'(roll_track) + 128) >>> 8, -32768, 32767));
    res.pitch_instant = 16'(p_inst);
    res.roll_instant = 16'(r_inst);
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Field value: extremes, zero, near-level values and full-range noise
  function automatic logic signed [15:0] pick_field();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd0;
      3, 4: return 16'($urandom_range(0, 400)) - 16'sd200;
      5, 6: return 16'($urandom_range(0, 32768)) - 16'sd16384;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void compare_field(string name, logic signed [15:0] want,
                                        logic signed [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Result side: random stall runs and a check of every accepted result
  always @(posedge clk) begin
    tilt_t want;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_tilt.size() == 0) begin
        errors++;
        $display("%0t ns: result with no request pending, pitch_est %0d", $time,
                 out_pitch_est);
      end else begin
        want = pending_tilt.pop_front();
        compare_field("pitch_est", want.pitch_est, out_pitch_est);
        compare_field("roll_est", want.roll_est, out_roll_est);
        compare_field("pitch_instant", want.pitch_instant, out_pitch_instant);
        compare_field("roll_instant", want.roll_instant, out_roll_instant);
      end
    end
    if (!rst_n || !idle_on) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_left = pick_pause();
    end else begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(0, 12);
    end
  end

  // One APB access; a read is compared with the predictor's register copy
  task automatic reg_access(logic reg_sel, logic is_write, logic [15:0] value);
    logic [31:0] want;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= {reg_sel, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (is_write) begin
      if (reg_sel == REG_BLEND_WEIGHT) alpha_q = value;
      else dt_q = value;
    end else begin
      want = {16'd0, (reg_sel == REG_BLEND_WEIGHT) ? alpha_q : dt_q};
      if (prdata !== want) begin
        errors++;
        $display("%0t ns: register %0d readback, expected %0d, got %0d", $time, reg_sel,
                 want, prdata);
      end
    end
  endtask

  // Send one request; the expectation is queued at the edge that accepts it
  task automatic send_sample(imu_sample_t s, logic pinned, tilt_t pinned_want);
    int gap;
    tilt_t predicted;
    gap = idle_on ? pick_pause() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_accel_x <= s.accel_x;
    in_accel_y <= s.accel_y;
    in_accel_z <= s.accel_z;
    in_rate_x <= s.rate_x;
    in_rate_y <= s.rate_y;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = advance_filter(s);
    pending_tilt.push_back(pinned ? pinned_want : predicted);
  endtask

  // Hold off requests until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_tilt.size() != 0);
  endtask

  // Directed requests under the reset register values
  probe_row_t probe_tab [14] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0}},
    '{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, '0},
    '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, -16'sd100, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, -16'sd1, -16'sd100, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, -16'sd100, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff}, 1'b0, '0},
    '{'{16'sd0, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd16384, 16'sh7fff, 16'sh8000}, 1'b0, '0},
    '{'{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555}, 1'b0, '0},
    '{'{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa}, 1'b0, '0}
  };

  // Register settings per phase, extremes first, then the defaults and random ones
  phase_t phase_tab [7];

  initial begin
    imu_sample_t s;
    phase_tab[0] = '{16'd65535, 16'd65535, 60, 1'b1, 1'b1};
    phase_tab[1] = '{16'd0, 16'd1, 50, 1'b0, 1'b0};
    phase_tab[2] = '{16'd32768, 16'd0, 50, 1'b1, 1'b0};
    phase_tab[3] = '{16'd1, 16'd65535, 50, 1'b1, 1'b1};
    phase_tab[4] = '{BLEND_WEIGHT_RESET, SAMPLE_PERIOD_RESET, 150, 1'b1, 1'b0};
    phase_tab[5] = '{16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)),
                     40, 1'b1, 1'b0};
    phase_tab[6] = '{16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)),
                     40, 1'b0, 1'b1};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values must read back before any write
    reg_access(REG_BLEND_WEIGHT, 1'b0, 16'd0);
    reg_access(REG_SAMPLE_PERIOD, 1'b0, 16'd0);

    // Directed part
    idle_on = 1'b1;
    foreach (probe_tab[i]) begin
      send_sample(probe_tab[i].sample, probe_tab[i].pinned, probe_tab[i].want);
    end
    drain();

    // Random phases, each under a fresh register setting written while idle
    foreach (phase_tab[p]) begin
      reg_access(REG_BLEND_WEIGHT, 1'b1, phase_tab[p].alpha);
      reg_access(REG_SAMPLE_PERIOD, 1'b1, phase_tab[p].dt);
      reg_access(REG_BLEND_WEIGHT, 1'b0, 16'd0);
      reg_access(REG_SAMPLE_PERIOD, 1'b0, 16'd0);
      idle_on = phase_tab[p].idling;
      for (int n = 0; n < phase_tab[p].count; n++) begin
        s.accel_x = pick_field();
        s.accel_y = pick_field();
        s.accel_z = pick_field();
        s.rate_x = pick_field();
        s.rate_y = pick_field();
        // Hold the rates at full scale for a while to drive the estimates into saturation
        if (phase_tab[p].rate_push && n < 30) begin
          s.rate_x = (n < 15) ? 16'sh7fff : 16'sh8000;
          s.rate_y = (n < 15) ? 16'sh7fff : 16'sh8000;
        end
        send_sample(s, 1'b0, '0);
        // Once, mid-way through the phase at the default registers, let the block run completely dry
        if (p == 4 && n == phase_tab[p].count / 2) drain();
      end
      drain();
    end

    idle_on = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_tilt.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

>>> complementary_tilt_filter_unit.f
rtl/ctf_pkg.sv
rtl/ctf_front.sv
rtl/ctf_sqrt.sv
rtl/ctf_cordic.sv
rtl/ctf_back.sv
rtl/complementary_tilt_filter_unit.sv
tb/tb_complementary_tilt_filter_unit.sv
